/* sv/dadd_pkg.sv */
// dadd_pkg: shared types, constants, calendar tables and sequencer codes for date_add_days
`default_nettype none

package dadd_pkg;

    localparam int OFFSET_BITS_DEF = 21;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int STATUS_W = 2;
    localparam int YLEN_W   = 9;

    localparam logic [YEAR_W-1:0]  MAX_YEAR      = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTHS        = 4'd12;
    localparam logic [YLEN_W-1:0]  DAYS_PER_YEAR = 9'd365;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_DATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

    // program addresses
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MLOOP,
        S_ADDOFF,
        S_YCHK,
        S_FWD,
        S_FCHK,
        S_BACK,
        S_BADD,
        S_MSPL,
        S_BAD,
        S_RANGE,
        S_EMIT
    } t_step;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT,
        OP_ADD_MONTH,
        OP_ADD_OFF,
        OP_SET_K1,
        OP_YEAR_UP,
        OP_YEAR_DOWN,
        OP_ADD_YEAR,
        OP_SUB_MONTH,
        OP_SET_BAD,
        OP_SET_RANGE,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_NO_INPUT,
        C_BAD_DATE,
        C_MONTH_PEND,
        C_NEG,
        C_NOT_NEG,
        C_YEAR_FITS,
        C_YEAR_OVER,
        C_YEAR_ZERO,
        C_MONTH_FITS,
        C_OUT_BUSY
    } t_cond;

    // when the datapath operation of a step runs
    typedef enum logic [1:0] {
        EX_ALWAYS,
        EX_TAKEN,
        EX_NOT_TAKEN
    } t_exec;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_exec exec;
        t_step jt;
        t_step nx;
        logic  take;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic take;
    } t_ctrl;

    typedef struct packed {
        logic bad_date;
        logic month_pend;
        logic neg;
        logic year_fits;
        logic year_over;
        logic year_zero;
        logic month_fits;
        logic out_busy;
    } t_flags;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    // y / 100 by reciprocal, exact for every 14-bit year
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [26:0]       prod;
        logic [7:0]        q;
        logic [YEAR_W-1:0] hund;
        logic              cent;
        prod = 27'(y) * 27'd5243;
        q    = prod[26:19];
        hund = 14'({q, 6'b0}) + 14'({q, 5'b0}) + 14'({q, 2'b0});
        cent = (y == hund);
        return (y[1:0] == 2'b00) && (!cent || (q[1:0] == 2'b00));
    endfunction

endpackage

`default_nettype wire

/* sv/dadd_if.sv */
// dadd_if: handshake channels carrying the date beats in and the result beats out
`default_nettype none

interface dadd_in_if #(
    parameter int OFFSET_BITS = dadd_pkg::OFFSET_BITS_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic        [dadd_pkg::YEAR_W-1:0]   start_year;
    logic        [dadd_pkg::MONTH_W-1:0]  start_month;
    logic        [dadd_pkg::DAY_W-1:0]    start_day;
    logic signed [OFFSET_BITS-1:0]        day_offset;

    modport source (output valid, start_year, start_month, start_day, day_offset,
                    input ready);
    modport sink   (input valid, start_year, start_month, start_day, day_offset,
                    output ready);
endinterface

interface dadd_out_if;
    logic                            valid;
    logic                            ready;
    logic [dadd_pkg::YEAR_W-1:0]     result_year;
    logic [dadd_pkg::MONTH_W-1:0]    result_month;
    logic [dadd_pkg::DAY_W-1:0]      result_day;
    logic [dadd_pkg::STATUS_W-1:0]   status;

    modport source (output valid, result_year, result_month, result_day, status,
                    input ready);
    modport sink   (input valid, result_year, result_month, result_day, status,
                    output ready);
endinterface

`default_nettype wire

/* sv/date_add_days.sv */
// date_add_days: top level, gregorian date plus signed day offset on a microcoded sequencer
// out-of-range results stop at the year limit
// throughput: one beat at a time, set by the two-step year loop of the sequencer
// the result register frees the input side, so the next beat is taken while a result waits
// reset clears the step counter and the result valid; no memory, no clearing pass
`default_nettype none

module date_add_days #(
    parameter int OFFSET_BITS = dadd_pkg::OFFSET_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dadd_in_if.sink    i_in,
    dadd_out_if.source o_res
);

    dadd_pkg::t_ctrl  w_ctrl;
    dadd_pkg::t_flags w_flags;

    dadd_ucode u_ucode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_flags    (w_flags),
        .o_ctrl     (w_ctrl)
    );

    dadd_dpath #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_in    (i_in),
        .o_res   (o_res),
        .o_flags (w_flags)
    );

    assign i_in.ready = w_ctrl.take;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken again right after a beat");

    a_no_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !$rose(o_res.valid))
        else $error("result appeared one cycle after the input beat");

    a_error_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status != dadd_pkg::ST_OK)) |->
        ((o_res.result_year == '0) && (o_res.result_month == '0) &&
         (o_res.result_day == '0)))
        else $error("error result carries a date");

    a_ok_date_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status == dadd_pkg::ST_OK)) |->
        ((o_res.result_year != '0) && (o_res.result_year <= dadd_pkg::MAX_YEAR) &&
         (o_res.result_month != '0) && (o_res.result_month <= dadd_pkg::MONTHS) &&
         (o_res.result_day != '0)))
        else $error("ok result with a date out of range");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.status == dadd_pkg::ST_OK) ||
                         (o_res.status == dadd_pkg::ST_BAD_DATE) ||
                         (o_res.status == dadd_pkg::ST_RANGE)))
        else $error("unknown status code");

endmodule

`default_nettype wire

/* sv/dadd_ucode.sv */
// dadd_ucode: microprogram store, step counter and jump logic
`default_nettype none

module dadd_ucode (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire dadd_pkg::t_flags i_flags,
    output dadd_pkg::t_ctrl       o_ctrl
);

    dadd_pkg::t_step  r_step;
    dadd_pkg::t_step  n_step;
    dadd_pkg::t_uword w_word;
    logic             w_taken;
    logic             w_run;

    function automatic dadd_pkg::t_uword rom(input dadd_pkg::t_step s);
        dadd_pkg::t_uword w;
        case (s)
            dadd_pkg::S_IDLE:   w = '{dadd_pkg::OP_LOAD, dadd_pkg::C_NO_INPUT,
                                      dadd_pkg::EX_NOT_TAKEN, dadd_pkg::S_IDLE,
                                      dadd_pkg::S_CHECK, 1'b1};
            dadd_pkg::S_CHECK:  w = '{dadd_pkg::OP_INIT, dadd_pkg::C_BAD_DATE,
                                      dadd_pkg::EX_NOT_TAKEN, dadd_pkg::S_BAD,
                                      dadd_pkg::S_MLOOP, 1'b0};
            dadd_pkg::S_MLOOP:  w = '{dadd_pkg::OP_ADD_MONTH, dadd_pkg::C_MONTH_PEND,
                                      dadd_pkg::EX_TAKEN, dadd_pkg::S_MLOOP,
                                      dadd_pkg::S_ADDOFF, 1'b0};
            dadd_pkg::S_ADDOFF: w = '{dadd_pkg::OP_ADD_OFF, dadd_pkg::C_NEVER,
                                      dadd_pkg::EX_ALWAYS, dadd_pkg::S_YCHK,
                                      dadd_pkg::S_YCHK, 1'b0};
            dadd_pkg::S_YCHK:   w = '{dadd_pkg::OP_SET_K1, dadd_pkg::C_NEG,
                                      dadd_pkg::EX_ALWAYS, dadd_pkg::S_BACK,
                                      dadd_pkg::S_FWD, 1'b0};
            dadd_pkg::S_FWD:    w = '{dadd_pkg::OP_YEAR_UP, dadd_pkg::C_YEAR_FITS,
                                      dadd_pkg::EX_NOT_TAKEN, dadd_pkg::S_MSPL,
                                      dadd_pkg::S_FCHK, 1'b0};
            dadd_pkg::S_FCHK:   w = '{dadd_pkg::OP_NOP, dadd_pkg::C_YEAR_OVER,
                                      dadd_pkg::EX_ALWAYS, dadd_pkg::S_RANGE,
                                      dadd_pkg::S_FWD, 1'b0};
            dadd_pkg::S_BACK:   w = '{dadd_pkg::OP_YEAR_DOWN, dadd_pkg::C_NOT_NEG,
                                      dadd_pkg::EX_NOT_TAKEN, dadd_pkg::S_MSPL,
                                      dadd_pkg::S_BADD, 1'b0};
            dadd_pkg::S_BADD:   w = '{dadd_pkg::OP_ADD_YEAR, dadd_pkg::C_YEAR_ZERO,
                                      dadd_pkg::EX_NOT_TAKEN, dadd_pkg::S_RANGE,
                                      dadd_pkg::S_BACK, 1'b0};
            dadd_pkg::S_MSPL:   w = '{dadd_pkg::OP_SUB_MONTH, dadd_pkg::C_MONTH_FITS,
                                      dadd_pkg::EX_NOT_TAKEN, dadd_pkg::S_EMIT,
                                      dadd_pkg::S_MSPL, 1'b0};
            dadd_pkg::S_BAD:    w = '{dadd_pkg::OP_SET_BAD, dadd_pkg::C_NEVER,
                                      dadd_pkg::EX_ALWAYS, dadd_pkg::S_EMIT,
                                      dadd_pkg::S_EMIT, 1'b0};
            dadd_pkg::S_RANGE:  w = '{dadd_pkg::OP_SET_RANGE, dadd_pkg::C_NEVER,
                                      dadd_pkg::EX_ALWAYS, dadd_pkg::S_EMIT,
                                      dadd_pkg::S_EMIT, 1'b0};
            dadd_pkg::S_EMIT:   w = '{dadd_pkg::OP_EMIT, dadd_pkg::C_OUT_BUSY,
                                      dadd_pkg::EX_NOT_TAKEN, dadd_pkg::S_EMIT,
                                      dadd_pkg::S_IDLE, 1'b0};
            default:            w = '{dadd_pkg::OP_NOP, dadd_pkg::C_NEVER,
                                      dadd_pkg::EX_ALWAYS, dadd_pkg::S_IDLE,
                                      dadd_pkg::S_IDLE, 1'b0};
        endcase
        return w;
    endfunction

    assign w_word = rom(r_step);

    always_comb begin
        case (w_word.cond)
            dadd_pkg::C_NEVER:      w_taken = 1'b0;
            dadd_pkg::C_NO_INPUT:   w_taken = !i_in_valid;
            dadd_pkg::C_BAD_DATE:   w_taken = i_flags.bad_date;
            dadd_pkg::C_MONTH_PEND: w_taken = i_flags.month_pend;
            dadd_pkg::C_NEG:        w_taken = i_flags.neg;
            dadd_pkg::C_NOT_NEG:    w_taken = !i_flags.neg;
            dadd_pkg::C_YEAR_FITS:  w_taken = i_flags.year_fits;
            dadd_pkg::C_YEAR_OVER:  w_taken = i_flags.year_over;
            dadd_pkg::C_YEAR_ZERO:  w_taken = i_flags.year_zero;
            dadd_pkg::C_MONTH_FITS: w_taken = i_flags.month_fits;
            dadd_pkg::C_OUT_BUSY:   w_taken = i_flags.out_busy;
            default:                w_taken = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        n_step = w_taken ? w_word.jt : w_word.nx;
    end

    // control outputs
    always_comb begin
        case (w_word.exec)
            dadd_pkg::EX_ALWAYS:    w_run = 1'b1;
            dadd_pkg::EX_TAKEN:     w_run = w_taken;
            dadd_pkg::EX_NOT_TAKEN: w_run = !w_taken;
            default:                w_run = 1'b0;
        endcase
        o_ctrl.op   = w_run ? w_word.op : dadd_pkg::OP_NOP;
        o_ctrl.take = w_word.take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= dadd_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

/* sv/dadd_dpath.sv */
// dadd_dpath: date registers, day-count adder, calendar lookups and result register
`default_nettype none

module dadd_dpath #(
    parameter int OFFSET_BITS = dadd_pkg::OFFSET_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dadd_pkg::t_ctrl i_ctrl,
    dadd_in_if.sink              i_in,
    dadd_out_if.source           o_res,
    output dadd_pkg::t_flags     o_flags
);

    localparam int RW = OFFSET_BITS + 2;

    logic        [dadd_pkg::YEAR_W-1:0]   r_year,  n_year;
    logic        [dadd_pkg::MONTH_W-1:0]  r_month, n_month;
    logic        [dadd_pkg::DAY_W-1:0]    r_day,   n_day;
    logic signed [OFFSET_BITS-1:0]        r_off,   n_off;
    logic        [dadd_pkg::MONTH_W-1:0]  r_k,     n_k;
    logic signed [RW-1:0]                 r_doy,   n_doy;
    logic                                 r_leap,  n_leap;
    logic        [dadd_pkg::STATUS_W-1:0] r_status, n_status;
    logic        [dadd_pkg::YEAR_W-1:0]   r_o_year,   n_o_year;
    logic        [dadd_pkg::MONTH_W-1:0]  r_o_month,  n_o_month;
    logic        [dadd_pkg::DAY_W-1:0]    r_o_day,    n_o_day;
    logic        [dadd_pkg::STATUS_W-1:0] r_o_status, n_o_status;
    logic                                 r_o_valid,  n_o_valid;

    logic        [dadd_pkg::DAY_W-1:0]    w_mlen;
    logic        [dadd_pkg::DAY_W-1:0]    w_slen;
    logic        [dadd_pkg::YLEN_W-1:0]   w_ylen;
    logic signed [RW-1:0]                 w_mlen_x;
    logic signed [RW-1:0]                 w_ylen_x;
    logic signed [RW-1:0]                 w_off_x;
    logic signed [RW-1:0]                 w_mdiff;
    logic signed [RW-1:0]                 w_ydiff;

    assign w_mlen   = dadd_pkg::month_days(r_k, r_leap);
    assign w_slen   = dadd_pkg::month_days(r_month, r_leap);
    assign w_ylen   = dadd_pkg::DAYS_PER_YEAR + dadd_pkg::YLEN_W'(r_leap);
    assign w_mlen_x = RW'(w_mlen);
    assign w_ylen_x = RW'(w_ylen);
    assign w_off_x  = {{2{r_off[OFFSET_BITS-1]}}, r_off};
    assign w_mdiff  = r_doy - w_mlen_x;
    assign w_ydiff  = r_doy - w_ylen_x;

    always_comb begin
        o_flags.bad_date   = (r_year == '0) || (r_year > dadd_pkg::MAX_YEAR) ||
                             (r_month == '0) || (r_month > dadd_pkg::MONTHS) ||
                             (r_day == '0) || (r_day > w_slen);
        o_flags.month_pend = (r_k < r_month);
        o_flags.neg        = r_doy[RW-1];
        o_flags.year_fits  = w_ydiff[RW-1];
        o_flags.year_over  = (r_year > dadd_pkg::MAX_YEAR);
        o_flags.year_zero  = (r_year == '0);
        o_flags.month_fits = w_mdiff[RW-1] || (r_k == dadd_pkg::MONTHS);
        o_flags.out_busy   = r_o_valid && !o_res.ready;
    end

    always_comb begin
        n_year     = r_year;
        n_month    = r_month;
        n_day      = r_day;
        n_off      = r_off;
        n_k        = r_k;
        n_doy      = r_doy;
        n_status   = r_status;
        n_o_year   = r_o_year;
        n_o_month  = r_o_month;
        n_o_day    = r_o_day;
        n_o_status = r_o_status;
        n_o_valid  = r_o_valid;
        if (r_o_valid && o_res.ready) begin
            n_o_valid = 1'b0;
        end
        case (i_ctrl.op)
            dadd_pkg::OP_LOAD: begin
                n_year  = i_in.start_year;
                n_month = i_in.start_month;
                n_day   = i_in.start_day;
                n_off   = i_in.day_offset;
            end
            dadd_pkg::OP_INIT: begin
                n_doy    = RW'(r_day - 5'd1);
                n_k      = 4'd1;
                n_status = dadd_pkg::ST_OK;
            end
            dadd_pkg::OP_ADD_MONTH: begin
                n_doy = r_doy + w_mlen_x;
                n_k   = r_k + 4'd1;
            end
            dadd_pkg::OP_ADD_OFF: begin
                n_doy = r_doy + w_off_x;
            end
            dadd_pkg::OP_SET_K1: begin
                n_k = 4'd1;
            end
            dadd_pkg::OP_YEAR_UP: begin
                n_doy  = w_ydiff;
                n_year = r_year + 14'd1;
            end
            dadd_pkg::OP_YEAR_DOWN: begin
                n_year = r_year - 14'd1;
            end
            dadd_pkg::OP_ADD_YEAR: begin
                n_doy = r_doy + w_ylen_x;
            end
            dadd_pkg::OP_SUB_MONTH: begin
                n_doy = w_mdiff;
                n_k   = r_k + 4'd1;
            end
            dadd_pkg::OP_SET_BAD: begin
                n_status = dadd_pkg::ST_BAD_DATE;
            end
            dadd_pkg::OP_SET_RANGE: begin
                n_status = dadd_pkg::ST_RANGE;
            end
            dadd_pkg::OP_EMIT: begin
                n_o_valid  = 1'b1;
                n_o_status = r_status;
                if (r_status == dadd_pkg::ST_OK) begin
                    n_o_year  = r_year;
                    n_o_month = r_k;
                    n_o_day   = r_doy[dadd_pkg::DAY_W-1:0] + 5'd1;
                end else begin
                    n_o_year  = '0;
                    n_o_month = '0;
                    n_o_day   = '0;
                end
            end
            default: begin
            end
        endcase
        // leap flag always tracks the year register
        n_leap = dadd_pkg::is_leap(n_year);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_year     <= n_year;
        r_month    <= n_month;
        r_day      <= n_day;
        r_off      <= n_off;
        r_k        <= n_k;
        r_doy      <= n_doy;
        r_leap     <= n_leap;
        r_status   <= n_status;
        r_o_year   <= n_o_year;
        r_o_month  <= n_o_month;
        r_o_day    <= n_o_day;
        r_o_status <= n_o_status;
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.result_year  = r_o_year;
    assign o_res.result_month = r_o_month;
    assign o_res.result_day   = r_o_day;
    assign o_res.status       = r_o_status;

endmodule

`default_nettype wire

/* tb/date_add_days_tb.sv */
// date_add_days_tb: self-checking bench for date_add_days, calendar edge cases then random dates
`timescale 1ns / 100ps

module date_add_days_tb;

    localparam int     OFF_W          = dadd_pkg::OFFSET_BITS_DEF;
    localparam int     CLK_PERIOD     = 12;
    localparam int     RESET_CYCLES   = 7;
    localparam int     PLAN_ROWS      = 25;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     TAIL_CYCLES    = 200;
    localparam longint LIMIT_NS       = 48_000_000;
    localparam int     YEAR_DAYS      = 365;
    localparam int     QUAD_DAYS      = 1461;
    localparam int     CENT_DAYS      = 36524;
    localparam int     QUAD_CENT_DAYS = 146097;

    typedef struct packed {
        logic        [dadd_pkg::YEAR_W-1:0]  year;
        logic        [dadd_pkg::MONTH_W-1:0] month;
        logic        [dadd_pkg::DAY_W-1:0]   day;
        logic signed [OFF_W-1:0]             offset;
    } t_date_beat;

    typedef struct packed {
        logic [dadd_pkg::YEAR_W-1:0]   year;
        logic [dadd_pkg::MONTH_W-1:0]  month;
        logic [dadd_pkg::DAY_W-1:0]    day;
        logic [dadd_pkg::STATUS_W-1:0] status;
    } t_shifted_date;

    typedef struct {
        int                            y;
        int                            m;
        int                            d;
        int                            off;
        bit                            pinned;
        int                            ry;
        int                            rm;
        int                            rd;
        logic [dadd_pkg::STATUS_W-1:0] st;
    } t_plan_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dadd_in_if #(.OFFSET_BITS(OFF_W)) in_ch ();
    dadd_out_if                       res_ch ();

    date_add_days #(.OFFSET_BITS(OFF_W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    t_shifted_date pending_dates[$];
    int            mismatches = 0;
    int            beats_sent = 0;
    int            n_ok       = 0;
    int            n_bad_date = 0;
    int            n_range    = 0;
    bit            no_idle    = 1'b0;
    bit            hold_req   = 1'b0;

    // y, m, d, offset, pinned, expected y, m, d, status
    t_plan_row plan [PLAN_ROWS] = '{
        '{    1,  1,  1,        0, 1,    1,  1,  1, dadd_pkg::ST_OK},
        '{ 9999, 12, 31,        0, 1, 9999, 12, 31, dadd_pkg::ST_OK},
        '{ 9999, 12, 31,        1, 1,    0,  0,  0, dadd_pkg::ST_RANGE},
        '{    1,  1,  1,       -1, 1,    0,  0,  0, dadd_pkg::ST_RANGE},
        '{    0,  1,  1,        0, 1,    0,  0,  0, dadd_pkg::ST_BAD_DATE},
        '{10000,  1,  1,        0, 1,    0,  0,  0, dadd_pkg::ST_BAD_DATE},
        '{16383, 15, 31,       -1, 1,    0,  0,  0, dadd_pkg::ST_BAD_DATE},
        '{ 2000,  0,  1,        5, 1,    0,  0,  0, dadd_pkg::ST_BAD_DATE},
        '{ 2000, 13,  1,        5, 1,    0,  0,  0, dadd_pkg::ST_BAD_DATE},
        '{ 2000,  1,  0,        5, 1,    0,  0,  0, dadd_pkg::ST_BAD_DATE},
        '{ 2001,  4, 31,        0, 1,    0,  0,  0, dadd_pkg::ST_BAD_DATE},
        '{ 1900,  2, 29,        0, 1,    0,  0,  0, dadd_pkg::ST_BAD_DATE},
        '{ 2023,  2, 29,        0, 1,    0,  0,  0, dadd_pkg::ST_BAD_DATE},
        '{ 2000,  2, 30,        0, 1,    0,  0,  0, dadd_pkg::ST_BAD_DATE},
        '{ 2000,  2, 29,        0, 1, 2000,  2, 29, dadd_pkg::ST_OK},
        '{ 2024,  2, 28,        1, 1, 2024,  2, 29, dadd_pkg::ST_OK},
        '{ 2001,  1,  1,       -1, 1, 2000, 12, 31, dadd_pkg::ST_OK},
        '{    1,  1,  2,       -1, 1,    1,  1,  1, dadd_pkg::ST_OK},
        '{ 2100,  3,  1,       -1, 1, 2100,  2, 28, dadd_pkg::ST_OK},
        '{    1,  3,  1,      -60, 1,    0,  0,  0, dadd_pkg::ST_RANGE},
        '{ 9998,  1,  1,  1048575, 1,    0,  0,  0, dadd_pkg::ST_RANGE},
        '{    1,  1,  1,  1048575, 0,    0,  0,  0, dadd_pkg::ST_OK},
        '{ 9999, 12, 31, -1048576, 0,    0,  0,  0, dadd_pkg::ST_OK},
        '{ 5000,  6, 15, -1048576, 0,    0,  0,  0, dadd_pkg::ST_OK},
        '{ 1600,  2, 29,      366, 0,    0,  0,  0, dadd_pkg::ST_OK}
    };

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic bit leap_year(int y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int month_length(int y, int m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic longint days_to_year(int y);
        longint p;
        p = longint'(y) - 1;
        return YEAR_DAYS * p + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic t_shifted_date shift_date(t_date_beat b);
        t_shifted_date r;
        int            y, m, d, yr, mon;
        longint        serial, rem, n400, n100, n4, n1;
        r = '0;
        y = int'(b.year);
        m = int'(b.month);
        d = int'(b.day);
        if (y < 1 || y > int'(dadd_pkg::MAX_YEAR) || m < 1 || m > 12 ||
            d < 1 || d > month_length(y, m)) begin
            r.status = dadd_pkg::ST_BAD_DATE;
            return r;
        end
        serial = days_to_year(y);
        for (int i = 1; i < m; i++)
            serial += month_length(y, i);
        serial += longint'(d) - 1;
        serial += longint'($signed(b.offset));
        if (serial < 0 || serial > days_to_year(int'(dadd_pkg::MAX_YEAR) + 1) - 1) begin
            r.status = dadd_pkg::ST_RANGE;
            return r;
        end
        n400 = serial / QUAD_CENT_DAYS;
        rem  = serial % QUAD_CENT_DAYS;
        n100 = rem / CENT_DAYS;
        if (n100 > 3) n100 = 3;
        rem -= n100 * CENT_DAYS;
        n4   = rem / QUAD_DAYS;
        rem -= n4 * QUAD_DAYS;
        n1   = rem / YEAR_DAYS;
        if (n1 > 3) n1 = 3;
        rem -= n1 * YEAR_DAYS;
        yr   = int'(400 * n400 + 100 * n100 + 4 * n4 + n1 + 1);
        mon  = 1;
        while (mon < 12 && rem >= longint'(month_length(yr, mon))) begin
            rem -= month_length(yr, mon);
            mon++;
        end
        r.year   = dadd_pkg::YEAR_W'(yr);
        r.month  = dadd_pkg::MONTH_W'(mon);
        r.day    = dadd_pkg::DAY_W'(rem + 1);
        r.status = dadd_pkg::ST_OK;
        return r;
    endfunction

    // mostly valid dates; a share of raw junk, full-width offsets and dates near the year limits
    function automatic t_date_beat random_beat(bit near_only);
        t_date_beat b;
        int         y, m, d, mag, pick;
        pick = near_only ? 99 : $urandom_range(0, 99);
        y = $urandom_range(1, 9999);
        if (pick >= 20 && pick < 26)
            y = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(9996, 9999);
        m = $urandom_range(1, 12);
        d = ($urandom_range(0, 3) == 0) ? month_length(y, m)
                                        : $urandom_range(1, month_length(y, m));
        b.year  = dadd_pkg::YEAR_W'(y);
        b.month = dadd_pkg::MONTH_W'(m);
        b.day   = dadd_pkg::DAY_W'(d);
        if (pick < 8) begin
            b.year   = dadd_pkg::YEAR_W'($urandom);
            b.month  = dadd_pkg::MONTH_W'($urandom);
            b.day    = dadd_pkg::DAY_W'($urandom);
            b.offset = OFF_W'($urandom);
        end else if (pick < 20) begin
            b.offset = OFF_W'($urandom);
        end else begin
            mag = $urandom_range(0, (pick < 26) ? 3000 : (pick < 50) ? 60000 : 1500);
            b.offset = $urandom_range(0, 1) ? OFF_W'(-mag) : OFF_W'(mag);
        end
        return b;
    endfunction

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 15) return $urandom_range(1, 3);
        if (roll < 19) return $urandom_range(4, 12);
        return $urandom_range(40, 120);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic send_date(input t_date_beat b, input bit pinned, input t_shifted_date want);
        int gap;
        gap = (no_idle || $urandom_range(0, 1)) ? 0 : idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.start_year  <= b.year;
        in_ch.start_month <= b.month;
        in_ch.start_day   <= b.day;
        in_ch.day_offset  <= b.offset;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_dates.push_back(pinned ? want : shift_date(b));
        beats_sent++;
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic send_random(int count, bit near_only);
        repeat (count) send_date(random_beat(near_only), 1'b0, '0);
    endtask

    always @(posedge i_clk) begin : check_results
        t_shifted_date want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_dates.size() == 0) begin
                report_mismatch("result beat with nothing pending, status", res_ch.status, -1);
            end else begin
                want = pending_dates.pop_front();
                if (res_ch.status !== want.status)
                    report_mismatch("status", res_ch.status, want.status);
                if (res_ch.result_year !== want.year)
                    report_mismatch("result_year", res_ch.result_year, want.year);
                if (res_ch.result_month !== want.month)
                    report_mismatch("result_month", res_ch.result_month, want.month);
                if (res_ch.result_day !== want.day)
                    report_mismatch("result_day", res_ch.result_day, want.day);
                case (want.status)
                    dadd_pkg::ST_OK:       n_ok++;
                    dadd_pkg::ST_BAD_DATE: n_bad_date++;
                    default:               n_range++;
                endcase
            end
        end
    end

    initial begin : result_sink
        int held;
        res_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(negedge i_clk);
                res_ch.ready <= 1'b1;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                repeat (idle_len()) @(negedge i_clk);
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : date_source
        t_date_beat    b;
        t_shifted_date want;
        in_ch.valid       = 1'b0;
        in_ch.start_year  = '0;
        in_ch.start_month = '0;
        in_ch.start_day   = '0;
        in_ch.day_offset  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++) begin
            b.year       = dadd_pkg::YEAR_W'(plan[i].y);
            b.month      = dadd_pkg::MONTH_W'(plan[i].m);
            b.day        = dadd_pkg::DAY_W'(plan[i].d);
            b.offset     = OFF_W'(plan[i].off);
            want.year    = dadd_pkg::YEAR_W'(plan[i].ry);
            want.month   = dadd_pkg::MONTH_W'(plan[i].rm);
            want.day     = dadd_pkg::DAY_W'(plan[i].rd);
            want.status  = plan[i].st;
            send_date(b, plan[i].pinned, want);
        end
        send_random(40, 1'b0);

        // drain fully, then back the output up while beats keep coming
        drop_valid();
        while (pending_dates.size() != 0) @(posedge i_clk);
        no_idle  = 1'b1;
        hold_req = 1'b1;
        send_random(10, 1'b1);
        send_random(15, 1'b0);
        no_idle = 1'b0;
        send_random(50, 1'b0);
        drop_valid();

        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d date beats (%0d directed): %0d ok, %0d bad start date, %0d %s",
                 beats_sent, PLAN_ROWS, n_ok, n_bad_date, n_range, "out of range");
        $display("output held off %0d cycles once with input stalled, %0d mismatches",
                 HOLD_CYCLES, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("timeout with %0d results outstanding", pending_dates.size());
        $display("status: fail");
        $finish;
    end

endmodule
